// ===== hw/rtl/u8u16_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; every other RTL file in this folder imports this package.
`default_nettype none

package u8u16_pkg;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_BAD_LEAD  = 3'd1,
		ERR_BAD_CONT  = 3'd2,
		ERR_TRUNCATED = 3'd3,
		ERR_SURROGATE = 3'd4,
		ERR_TOO_LARGE = 3'd5
	} err_t;

	// Byte class limits, compared against the raw UTF-8 byte.
	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] CONT_MAX  = 8'hBF;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MAX = 8'hF7;
	localparam logic [7:0] CONT_MASK = 8'h3F;

	// Code point limits.
	localparam logic [20:0] SURR_LO  = 21'h00D800;
	localparam logic [20:0] SURR_HI  = 21'h00DFFF;
	localparam logic [20:0] CP_MAX   = 21'h10FFFF;
	localparam logic [20:0] BMP_SPAN = 21'h010000;

	// UTF-16 surrogate pair construction.
	localparam logic [15:0] HI_SURR_BASE = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
	localparam logic [15:0] SURR_MASK    = 16'h03FF;

	typedef struct packed {
		logic [15:0] code_unit;
		err_t        error_code;
		logic        last_of_run;
		logic        text_done;
	} result_t;

	// Up to two results produced by one decoded byte.
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/utf8_to_utf16_transcoder.sv =====
// UTF-8 to UTF-16 transcoder, top level: decode stage followed by the result
// buffer. Depends on u8u16_pkg, u8u16_decode and u8u16_outbuf.
`default_nettype none

// The block takes one UTF-8 byte per transaction, with end_of_text on the last
// byte of a text, and can accept a byte in every cycle when not stalled. A byte
// is registered and decoded once the buffer has room; its results are registered
// in the buffer. A code point above 0xFFFF yields a surrogate pair, and since the
// result port moves one unit per cycle unless stalled, the input holds off after
// a pair when the output is drained steadily. Errors yield a single result with
// code_unit zero; after an error, bytes give no results until end_of_text.
module utf8_to_utf16_transcoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  in_byte,
	input  wire logic        end_of_text,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [15:0]      code_unit,
	output logic [2:0]       error_code,
	output logic             last_of_run,
	output logic             text_done
);
	import u8u16_pkg::*;

	push_t   push;
	result_t head;
	logic    room;

	u8u16_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.room        (room),
		.push        (push)
	);

	u8u16_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.head         (head)
	);

	assign code_unit   = head.code_unit;
	assign error_code  = head.error_code;
	assign last_of_run = head.last_of_run;
	assign text_done   = head.text_done;

endmodule

`default_nettype wire

// ===== hw/rtl/u8u16_decode.sv =====
// Input register and decode stage: holds the sequence state and turns each
// byte into zero, one or two results. Depends on u8u16_pkg.
`default_nettype none

module u8u16_decode (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           byte_valid,
	output logic                byte_stall,
	input  wire logic [7:0]     in_byte,
	input  wire logic           end_of_text,
	input  wire logic           room,
	output u8u16_pkg::push_t    push
);
	import u8u16_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eot_s1;

	logic [1:0]  pend_q,  pend_d;
	logic [20:0] accum_q, accum_d;
	logic        drop_q,  drop_d;

	logic        adv;
	logic        take;
	logic        do_emit;
	logic [20:0] cp;
	logic [20:0] accum_sh;
	logic [20:0] supp;
	err_t        err;

	assign adv        = valid_s1 & room;
	assign byte_stall = valid_s1 & ~room;
	assign take       = byte_valid & ~byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pend_q   <= '0;
			accum_q  <= '0;
			drop_q   <= 1'b0;
		end else begin
			valid_s1 <= take | (valid_s1 & ~adv);
			pend_q   <= pend_d;
			accum_q  <= accum_d;
			drop_q   <= drop_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= in_byte;
			eot_s1  <= end_of_text;
		end
	end

	always_comb begin
		pend_d   = pend_q;
		accum_d  = accum_q;
		drop_d   = drop_q;
		do_emit  = 1'b0;
		cp       = '0;
		err      = ERR_NONE;
		accum_sh = {accum_q[14:0], byte_s1[5:0] & CONT_MASK[5:0]};
		supp     = '0;
		push     = '0;
		if (adv) begin
			if (drop_q) begin
				if (eot_s1) begin
					pend_d  = '0;
					accum_d = '0;
					drop_d  = 1'b0;
				end
			end else if (pend_q == 2'd0) begin
				priority if (byte_s1 <= ASCII_MAX) begin
					do_emit = 1'b1;
					cp      = {13'd0, byte_s1};
				end else if (byte_s1 <= CONT_MAX) begin
					err = ERR_BAD_LEAD;
				end else if (byte_s1 <= LEAD2_MAX) begin
					accum_d = {16'd0, byte_s1[4:0]};
					pend_d  = 2'd1;
					if (eot_s1) err = ERR_TRUNCATED;
				end else if (byte_s1 <= LEAD3_MAX) begin
					accum_d = {17'd0, byte_s1[3:0]};
					pend_d  = 2'd2;
					if (eot_s1) err = ERR_TRUNCATED;
				end else if (byte_s1 <= LEAD4_MAX) begin
					accum_d = {18'd0, byte_s1[2:0]};
					pend_d  = 2'd3;
					if (eot_s1) err = ERR_TRUNCATED;
				end else begin
					err = ERR_BAD_LEAD;
				end
			end else begin
				if (byte_s1[7:6] != 2'b10) begin
					err = ERR_BAD_CONT;
				end else begin
					accum_d = accum_sh;
					pend_d  = pend_q - 2'd1;
					if (pend_q == 2'd1) begin
						do_emit = 1'b1;
						cp      = accum_sh;
						accum_d = '0;
					end else if (eot_s1) begin
						err = ERR_TRUNCATED;
					end
				end
			end

			if (do_emit) begin
				if (cp >= SURR_LO && cp <= SURR_HI) begin
					err = ERR_SURROGATE;
				end else if (cp > CP_MAX) begin
					err = ERR_TOO_LARGE;
				end
			end

			if (err != ERR_NONE) begin
				// An error on the last byte closes the text without dropping.
				pend_d                = '0;
				accum_d               = '0;
				drop_d                = ~eot_s1;
				push.count            = 2'd1;
				push.r0.code_unit     = '0;
				push.r0.error_code    = err;
				push.r0.last_of_run   = 1'b1;
				push.r0.text_done     = eot_s1;
			end else if (do_emit) begin
				if (eot_s1) begin
					pend_d  = '0;
					accum_d = '0;
					drop_d  = 1'b0;
				end
				if (cp[20:16] == 5'd0) begin
					push.count          = 2'd1;
					push.r0.code_unit   = cp[15:0];
					push.r0.error_code  = ERR_NONE;
					push.r0.last_of_run = 1'b1;
					push.r0.text_done   = eot_s1;
				end else begin
					supp                = cp - BMP_SPAN;
					push.count          = 2'd2;
					push.r0.code_unit   = HI_SURR_BASE | {6'd0, supp[19:10]};
					push.r0.error_code  = ERR_NONE;
					push.r0.last_of_run = 1'b0;
					push.r0.text_done   = 1'b0;
					push.r1.code_unit   = LO_SURR_BASE | (supp[15:0] & SURR_MASK);
					push.r1.error_code  = ERR_NONE;
					push.r1.last_of_run = 1'b1;
					push.r1.text_done   = eot_s1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/u8u16_outbuf.sv =====
// Three-slot result buffer that presents one result per cycle from slot zero unless
// stalled. Takes up to two results per cycle from the decode stage. Depends on u8u16_pkg.
`default_nettype none

module u8u16_outbuf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire u8u16_pkg::push_t  push,
	output logic                   room,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output u8u16_pkg::result_t     head
);
	import u8u16_pkg::*;

	localparam int unsigned SLOTS = 3;

	result_t    slot_q [SLOTS];
	result_t    slot_d [SLOTS];
	logic [1:0] cnt_q, cnt_d;
	logic [1:0] cnt_pop;
	logic       pop;

	// Room is judged on the registered count so it never depends on the far stall.
	assign room         = (cnt_q <= 2'd1);
	assign result_valid = (cnt_q != 2'd0);
	assign pop          = result_valid & ~result_stall;
	assign head         = slot_q[0];
	assign cnt_pop      = cnt_q - {1'b0, pop};

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			if (pop && i < SLOTS - 1) begin
				slot_d[i] = slot_q[i + 1];
			end else begin
				slot_d[i] = slot_q[i];
			end
			if (push.count != 2'd0 && cnt_pop == 2'(i)) begin
				slot_d[i] = push.r0;
			end
			if (push.count == 2'd2 && cnt_pop + 2'd1 == 2'(i)) begin
				slot_d[i] = push.r1;
			end
		end
		cnt_d = cnt_pop + push.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOTS; i++) begin
			slot_q[i] <= slot_d[i];
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_utf8_to_utf16_transcoder.sv =====
// Self-checking testbench for utf8_to_utf16_transcoder: directed and random UTF-8 texts,
// with results predicted in a scoreboard class and checked in order.
// Depends on u8u16_pkg and the transcoder RTL under hw/rtl.
module tb_utf8_to_utf16_transcoder;
	timeunit 1ns;
	timeprecision 1ps;

	import u8u16_pkg::*;

	// Tracks decoder state, predicts the UTF-16 units each byte yields and checks them.
	class transcode_scoreboard;
		result_t     pending_units[$];
		logic [1:0]  waiting_cont;
		logic [20:0] accum;
		logic        dropping;
		int          live_bytes;
		int          units_checked;
		int          mismatches;
		int          pairs;
		int          kind_count[6];

		function new();
			clear_state();
		endfunction

		function void clear_state();
			waiting_cont = '0;
			accum = '0;
			dropping = 1'b0;
		endfunction

		function void push_unit(logic [15:0] unit, err_t err, logic last, logic done);
			result_t r;
			r.code_unit = unit;
			r.error_code = err;
			r.last_of_run = last;
			r.text_done = done;
			pending_units = {pending_units, r};
			kind_count[err]++;
		endfunction

		function void raise_error(err_t err, logic eot);
			waiting_cont = '0;
			accum = '0;
			dropping = !eot;
			push_unit(16'h0000, err, 1'b1, eot);
		endfunction

		function void finish_point(logic [20:0] cp, logic eot);
			logic [19:0] offset;
			if (cp >= 21'h00D800 && cp <= 21'h00DFFF) begin
				raise_error(ERR_SURROGATE, eot);
			end else if (cp > 21'h10FFFF) begin
				raise_error(ERR_TOO_LARGE, eot);
			end else begin
				if (eot)
					clear_state();
				if (cp <= 21'h00FFFF) begin
					push_unit(cp[15:0], ERR_NONE, 1'b1, eot);
				end else begin
					offset = cp[19:0] - 20'h10000;
					push_unit(16'hD800 + {6'd0, offset[19:10]}, ERR_NONE, 1'b0, 1'b0);
					push_unit(16'hDC00 + {6'd0, offset[9:0]}, ERR_NONE, 1'b1, eot);
					pairs++;
				end
			end
		endfunction

		function void note_byte(logic [7:0] b, logic eot);
			logic [20:0] cp;
			if (dropping) begin
				if (eot)
					clear_state();
				return;
			end
			live_bytes++;
			if (waiting_cont == 2'd0) begin
				if (b <= 8'h7F) begin
					finish_point({13'd0, b}, eot);
				end else if (b <= 8'hBF || b > 8'hF7) begin
					raise_error(ERR_BAD_LEAD, eot);
				end else begin
					if (b <= 8'hDF) begin
						accum = {16'd0, b[4:0]};
						waiting_cont = 2'd1;
					end else if (b <= 8'hEF) begin
						accum = {17'd0, b[3:0]};
						waiting_cont = 2'd2;
					end else begin
						accum = {18'd0, b[2:0]};
						waiting_cont = 2'd3;
					end
					if (eot)
						raise_error(ERR_TRUNCATED, eot);
				end
			end else if (b[7:6] != 2'b10) begin
				raise_error(ERR_BAD_CONT, eot);
			end else begin
				accum = {accum[14:0], b[5:0]};
				waiting_cont = waiting_cont - 2'd1;
				if (waiting_cont == 2'd0) begin
					cp = accum;
					accum = '0;
					finish_point(cp, eot);
				end else if (eot) begin
					raise_error(ERR_TRUNCATED, eot);
				end
			end
		endfunction

		task report_mismatch(string what);
			$display("[%0t] MISMATCH: %s", $realtime, what);
			mismatches++;
		endtask

		task check_unit(logic [15:0] unit, logic [2:0] err, logic last, logic done);
			result_t want;
			units_checked++;
			if (pending_units.size() == 0) begin
				report_mismatch($sformatf("unexpected unit %h err %0d last %b done %b",
					unit, err, last, done));
				return;
			end
			want = pending_units.pop_front();
			if (unit !== want.code_unit)
				report_mismatch($sformatf("code_unit %h, expected %h", unit, want.code_unit));
			if (err !== want.error_code)
				report_mismatch($sformatf("error_code %0d, expected %0d", err, want.error_code));
			if (last !== want.last_of_run)
				report_mismatch($sformatf("last_of_run %b, expected %b", last, want.last_of_run));
			if (done !== want.text_done)
				report_mismatch($sformatf("text_done %b, expected %b", done, want.text_done));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  in_byte = '0;
	logic        end_of_text = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [15:0] code_unit;
	logic [2:0]  error_code;
	logic        last_of_run;
	logic        text_done;

	transcode_scoreboard sb = new();
	logic [7:0] text_bytes[$];

	utf8_to_utf16_transcoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.code_unit   (code_unit),
		.error_code  (error_code),
		.last_of_run (last_of_run),
		.text_done   (text_done)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Neither side idles during this stretch of the random traffic.
	function automatic bit steady_stretch();
		return sb.live_bytes >= 600 && sb.live_bytes < 900;
	endfunction

	function automatic void append_byte(logic [7:0] b);
		text_bytes = {text_bytes, b};
	endfunction

	function automatic void append_utf8(logic [20:0] cp, int len);
		case (len)
			1: begin
				append_byte({1'b0, cp[6:0]});
			end
			2: begin
				append_byte({3'b110, cp[10:6]});
				append_byte({2'b10, cp[5:0]});
			end
			3: begin
				append_byte({4'b1110, cp[15:12]});
				append_byte({2'b10, cp[11:6]});
				append_byte({2'b10, cp[5:0]});
			end
			default: begin
				append_byte({5'b11110, cp[20:18]});
				append_byte({2'b10, cp[17:12]});
				append_byte({2'b10, cp[11:6]});
				append_byte({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	// Entered and left at a falling edge; returns once the byte has been accepted.
	task automatic send_byte(input logic [7:0] b, input logic eot);
		while (!steady_stretch() && $urandom_range(99) < 7) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		in_byte <= b;
		end_of_text <= eot;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		sb.note_byte(b, eot);
		@(negedge clk);
	endtask

	task automatic send_text();
		for (int i = 0; i < text_bytes.size(); i++)
			send_byte(text_bytes[i], i == text_bytes.size() - 1);
		text_bytes.delete();
	endtask

	task automatic send_random_text();
		int          n;
		int          len;
		logic [20:0] cp;
		logic [7:0]  bad;
		if ($urandom_range(99) < 8) begin
			// Raw noise, with end of text scattered at random.
			n = $urandom_range(6, 1);
			for (int j = 0; j < n; j++)
				send_byte(8'($urandom_range(255)), j == n - 1 || $urandom_range(3) == 0);
			return;
		end
		n = $urandom_range(8, 1);
		for (int j = 0; j < n; j++) begin
			len = $urandom_range(4, 1);
			case (len)
				1: cp = 21'($urandom_range(8'h7F));
				2: cp = 21'($urandom_range(12'h7FF));
				3: cp = 21'($urandom_range(16'hFFFF));
				default: begin
					if ($urandom_range(9) == 0)
						cp = 21'($urandom_range(21'h1FFFFF, 21'h110000));
					else
						cp = 21'($urandom_range(21'h10FFFF, 21'h010000));
				end
			endcase
			append_utf8(cp, len);
			// Now and then break the sequence: cut it short or spoil its last byte.
			if (len > 1 && $urandom_range(99) < 8) begin
				if ($urandom_range(1) == 0) begin
					void'(text_bytes.pop_back());
				end else begin
					bad = 8'($urandom_range(255));
					if (bad[7:6] == 2'b10)
						bad[6] = 1'b1;
					text_bytes[text_bytes.size() - 1] = bad;
				end
			end
		end
		send_text();
	endtask

	// Receiver: random stalls, plus one long hold-off that backs the block up.
	initial begin
		int  hold_left;
		bit  held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && sb.live_bytes >= 200) begin
				held = 1'b1;
				hold_left = 150;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= !steady_stretch() && $urandom_range(99) < 7;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_unit(code_unit, error_code, last_of_run, text_done);
	end

	initial begin
		#1_000_000;
		$display("Run timed out with %0d units still expected.", sb.pending_units.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ASCII extremes, the last one closing the text.
		text_bytes = '{8'h00, 8'h7F};
		send_text();
		// Two- and three-byte limits, with an overlong zero in between.
		append_utf8(21'h0007FF, 2);
		append_utf8(21'h000000, 2);
		append_utf8(21'h00FFFF, 3);
		send_text();
		// A surrogate value mid-text; the byte after it is dropped.
		append_utf8(21'h00DFFF, 3);
		append_byte(8'h41);
		send_text();
		// Lowest and highest surrogate pairs.
		append_utf8(21'h010000, 4);
		append_utf8(21'h10FFFF, 4);
		send_text();
		append_utf8(21'h1FFFFF, 4);
		send_text();
		// Stray continuation byte as the whole text, then an invalid lead mid-text.
		text_bytes = '{8'h80};
		send_text();
		text_bytes = '{8'hFF, 8'hF0};
		send_text();
		// Text ending on a lead byte, and ending inside a continuation run.
		text_bytes = '{8'hE2};
		send_text();
		text_bytes = '{8'hF0, 8'h90};
		send_text();
		// A lead where a continuation belongs, on the last byte.
		text_bytes = '{8'hC3, 8'hC3};
		send_text();

		while (sb.live_bytes < 1300)
			send_random_text();
		byte_valid <= 1'b0;

		while (sb.pending_units.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Decoded %0d bytes into %0d checked units, %0d of them surrogate pairs.",
			sb.live_bytes, sb.units_checked, sb.pairs);
		$display("Errors: bad lead %0d, bad continuation %0d, truncated %0d,",
			sb.kind_count[ERR_BAD_LEAD], sb.kind_count[ERR_BAD_CONT],
			sb.kind_count[ERR_TRUNCATED]);
		$display("        surrogate %0d, too large %0d.",
			sb.kind_count[ERR_SURROGATE], sb.kind_count[ERR_TOO_LARGE]);
		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/u8u16_pkg.sv
hw/rtl/u8u16_decode.sv
hw/rtl/u8u16_outbuf.sv
hw/rtl/utf8_to_utf16_transcoder.sv
tb/sv/tb_utf8_to_utf16_transcoder.sv
